[rtl/dsa_pkg.sv]
// Shared types, constants and helpers for the descriptor slot allocator.
package dsa_pkg;

    localparam int MAX_SLOTS = 1024;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int CNT_W     = SLOT_W + 1;
    localparam int HANDLE_W  = 64;
    localparam int SIZE_W    = 12;
    localparam int SPAN_W    = SLOT_W + SIZE_W;
    localparam int STEP_W    = $clog2(SLOT_W);
    localparam int CFG_IDX_W = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W    = QPTR_W + 1;

    localparam logic [CNT_W-1:0]    MAX_COUNT   = CNT_W'(MAX_SLOTS);
    localparam logic [HANDLE_W-1:0] BASE_RESET  = '0;
    localparam logic [SIZE_W-1:0]   SIZE_RESET  = SIZE_W'(32);
    localparam logic [CNT_W-1:0]    COUNT_RESET = MAX_COUNT;

    localparam logic [CFG_IDX_W-1:0] REG_BASE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SIZE  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = CFG_IDX_W'(2);

    typedef enum logic [1:0] {
        CMD_POP     = 2'd0,
        CMD_PUSH    = 2'd1,
        CMD_RESERVE = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOT_FREE = 2'd2,
        ST_BAD      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SUB,
        F_CHK,
        F_DIV,
        F_EMIT
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_PRD,
        B_SCMP,
        B_SHIFT,
        B_MUL,
        B_ADD,
        B_DONE
    } back_state_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] base;
        logic [SIZE_W-1:0]   size;
        logic [CNT_W-1:0]    count;
    } cfg_t;

    typedef struct packed {
        logic             req;
        logic [CNT_W-1:0] count;
    } refill_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [SLOT_W-1:0] slot;
        logic              bad;
    } entry_t;

    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = CNT_W'(1);
        end
        else if (v > MAX_COUNT)
        begin
            r = MAX_COUNT;
        end
        return r;
    endfunction

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = SIZE_W'(1);
        end
        return r;
    endfunction

endpackage

[rtl/dsa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module dsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/dsa_front.sv]
// Front end: accepts commands, turns push handles into slots, flags bad handles.
module dsa_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  dsa_pkg::cmd_t                  cmd,
    input  logic [dsa_pkg::HANDLE_W-1:0]   handle_in,
    input  logic [dsa_pkg::SLOT_W-1:0]     slot_in,
    input  dsa_pkg::cfg_t                  cfg,
    output logic                           q_push,
    output dsa_pkg::entry_t                q_entry,
    input  logic                           q_full
);

    dsa_pkg::front_state_t               state_reg, state_next;
    dsa_pkg::cmd_t                       cmd_reg;
    logic [dsa_pkg::HANDLE_W-1:0]        handle_reg;
    logic [dsa_pkg::SLOT_W-1:0]          slot_reg;
    logic                                bad_reg;
    logic [dsa_pkg::HANDLE_W-1:0]        off_reg;
    logic                                below_reg;
    logic [dsa_pkg::SPAN_W-1:0]          span_reg;
    logic [dsa_pkg::SPAN_W-1:0]          rem_reg;
    logic [dsa_pkg::STEP_W-1:0]          step_reg;
    logic [dsa_pkg::SPAN_W-1:0]          trial;
    logic                                range_bad;
    logic [dsa_pkg::SPAN_W:0]            div_bound;

    assign trial     = dsa_pkg::SPAN_W'(cfg.size) << step_reg;
    assign div_bound = (dsa_pkg::SPAN_W+1)'(cfg.size) << (step_reg + 1'b1);
    assign range_bad = below_reg
                    || (off_reg[dsa_pkg::HANDLE_W-1:dsa_pkg::SPAN_W] != '0)
                    || (off_reg[dsa_pkg::SPAN_W-1:0] >= span_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dsa_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = (state_reg != dsa_pkg::F_IDLE);
        q_push     = 1'b0;
        q_entry    = '{cmd: cmd_reg, slot: slot_reg, bad: bad_reg || (rem_reg != '0)};
        case (state_reg)
            dsa_pkg::F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (cmd == dsa_pkg::CMD_PUSH) ? dsa_pkg::F_SUB
                                                            : dsa_pkg::F_EMIT;
                end
            end
            dsa_pkg::F_SUB:
            begin
                state_next = dsa_pkg::F_CHK;
            end
            dsa_pkg::F_CHK:
            begin
                state_next = range_bad ? dsa_pkg::F_EMIT : dsa_pkg::F_DIV;
            end
            dsa_pkg::F_DIV:
            begin
                if (step_reg == '0)
                begin
                    state_next = dsa_pkg::F_EMIT;
                end
            end
            dsa_pkg::F_EMIT:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = dsa_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = dsa_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            dsa_pkg::F_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_reg    <= cmd;
                    handle_reg <= handle_in;
                    slot_reg   <= (cmd == dsa_pkg::CMD_RESERVE) ? slot_in : '0;
                    bad_reg    <= 1'b0;
                    rem_reg    <= '0;
                end
            end
            dsa_pkg::F_SUB:
            begin
                off_reg   <= handle_reg - cfg.base;
                below_reg <= handle_reg < cfg.base;
                span_reg  <= dsa_pkg::SPAN_W'(cfg.count) * dsa_pkg::SPAN_W'(cfg.size);
            end
            dsa_pkg::F_CHK:
            begin
                slot_reg <= '0;
                if (range_bad)
                begin
                    bad_reg <= 1'b1;
                end
                else
                begin
                    rem_reg  <= off_reg[dsa_pkg::SPAN_W-1:0];
                    step_reg <= dsa_pkg::STEP_W'(dsa_pkg::SLOT_W - 1);
                end
            end
            dsa_pkg::F_DIV:
            begin
                if (rem_reg >= trial)
                begin
                    rem_reg            <= rem_reg - trial;
                    slot_reg[step_reg] <= 1'b1;
                end
                step_reg <= step_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dsa_pkg::F_DIV) |-> ({1'b0, rem_reg} < div_bound))
        else $error("division remainder above bound");

endmodule

[rtl/dsa_queue.sv]
// Two-entry queue between the front end and the stack engine.
module dsa_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  dsa_pkg::entry_t  push_entry,
    output logic             full,
    input  logic             pop,
    output dsa_pkg::entry_t  head,
    output logic             empty
);

    dsa_pkg::entry_t                 slots_reg [dsa_pkg::QUEUE_DEPTH];
    logic [dsa_pkg::QPTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [dsa_pkg::QCNT_W-1:0]      cnt_reg;
    logic                            do_push, do_pop;

    assign full    = (cnt_reg == dsa_pkg::QCNT_W'(dsa_pkg::QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign head    = slots_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= dsa_pkg::QCNT_W'(dsa_pkg::QUEUE_DEPTH))
        else $error("queue count overflow");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

endmodule

[rtl/dsa_back.sv]
// Stack engine: pop, push and reserve on the free-slot stack, result register.
module dsa_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dsa_pkg::cfg_t                 cfg,
    input  dsa_pkg::refill_t              refill,
    input  dsa_pkg::entry_t               q_head,
    input  logic                          q_empty,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [dsa_pkg::HANDLE_W-1:0]  handle_out,
    output logic [dsa_pkg::SLOT_W-1:0]    slot_out,
    output logic [1:0]                    status,
    output logic [dsa_pkg::CNT_W-1:0]     free_count
);

    dsa_pkg::back_state_t             state_reg, state_next;
    logic [dsa_pkg::CNT_W-1:0]        depth_reg, depth_next;
    logic [dsa_pkg::CNT_W-1:0]        low_reg, low_next;
    logic [dsa_pkg::SLOT_W-1:0]       idx_reg, idx_next;
    logic [dsa_pkg::SLOT_W-1:0]       fidx_reg, fidx_next;
    logic [dsa_pkg::SLOT_W-1:0]       slot_reg, slot_next;
    logic [dsa_pkg::SPAN_W-1:0]       mul_reg, mul_next;
    logic [dsa_pkg::HANDLE_W-1:0]     hnd_reg, hnd_next;
    dsa_pkg::status_t                 st_reg, st_next;
    logic                             virt_reg;
    logic [dsa_pkg::SLOT_W-1:0]       vval_reg;
    logic                             out_valid_reg;
    logic [dsa_pkg::HANDLE_W-1:0]     out_handle_reg;
    logic [dsa_pkg::SLOT_W-1:0]       out_slot_reg;
    dsa_pkg::status_t                 out_status_reg;
    logic [dsa_pkg::CNT_W-1:0]        out_count_reg;
    logic                             load_out;

    logic                             we, re;
    logic [dsa_pkg::SLOT_W-1:0]       waddr, raddr, wdata, ram_q, rd_val;
    logic [dsa_pkg::CNT_W-1:0]        depth_m1, idx_p1, idx_p2, vval_full;

    dsa_ram #(
        .WIDTH (dsa_pkg::SLOT_W),
        .DEPTH (dsa_pkg::MAX_SLOTS)
    ) u_stack (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (ram_q)
    );

    assign rd_val    = virt_reg ? vval_reg : ram_q;
    assign depth_m1  = depth_reg - 1'b1;
    assign idx_p1    = {1'b0, idx_reg} + dsa_pkg::CNT_W'(1);
    assign idx_p2    = {1'b0, idx_reg} + dsa_pkg::CNT_W'(2);
    assign vval_full = cfg.count - dsa_pkg::CNT_W'(1) - {1'b0, raddr};

    always_comb
    begin
        state_next = state_reg;
        depth_next = depth_reg;
        low_next   = low_reg;
        idx_next   = idx_reg;
        fidx_next  = fidx_reg;
        slot_next  = slot_reg;
        mul_next   = mul_reg;
        hnd_next   = hnd_reg;
        st_next    = st_reg;
        q_pop      = 1'b0;
        we         = 1'b0;
        waddr      = idx_reg;
        wdata      = rd_val;
        re         = 1'b0;
        raddr      = idx_reg;
        load_out   = 1'b0;
        case (state_reg)
            dsa_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    st_next   = dsa_pkg::ST_OK;
                    hnd_next  = '0;
                    slot_next = '0;
                    idx_next  = '0;
                    case (q_head.cmd)
                        dsa_pkg::CMD_POP:
                        begin
                            if (depth_reg == '0)
                            begin
                                st_next    = dsa_pkg::ST_EMPTY;
                                state_next = dsa_pkg::B_DONE;
                            end
                            else
                            begin
                                depth_next = depth_m1;
                                re         = 1'b1;
                                raddr      = depth_m1[dsa_pkg::SLOT_W-1:0];
                                state_next = dsa_pkg::B_PRD;
                            end
                        end
                        dsa_pkg::CMD_PUSH:
                        begin
                            if (q_head.bad || (depth_reg >= cfg.count))
                            begin
                                st_next = dsa_pkg::ST_BAD;
                            end
                            else
                            begin
                                we         = 1'b1;
                                waddr      = depth_reg[dsa_pkg::SLOT_W-1:0];
                                wdata      = q_head.slot;
                                slot_next  = q_head.slot;
                                depth_next = depth_reg + 1'b1;
                                if (depth_reg < low_reg)
                                begin
                                    low_next = depth_reg;
                                end
                            end
                            state_next = dsa_pkg::B_DONE;
                        end
                        dsa_pkg::CMD_RESERVE:
                        begin
                            if (depth_reg == '0)
                            begin
                                st_next    = dsa_pkg::ST_NOT_FREE;
                                state_next = dsa_pkg::B_DONE;
                            end
                            else
                            begin
                                slot_next  = q_head.slot;
                                re         = 1'b1;
                                raddr      = '0;
                                state_next = dsa_pkg::B_SCMP;
                            end
                        end
                        default:
                        begin
                            state_next = dsa_pkg::B_DONE;
                        end
                    endcase
                end
            end
            dsa_pkg::B_PRD:
            begin
                slot_next  = rd_val;
                state_next = dsa_pkg::B_MUL;
            end
            dsa_pkg::B_SCMP:
            begin
                if (rd_val == slot_reg)
                begin
                    fidx_next = idx_reg;
                    if (idx_p1 < depth_reg)
                    begin
                        re         = 1'b1;
                        raddr      = idx_p1[dsa_pkg::SLOT_W-1:0];
                        state_next = dsa_pkg::B_SHIFT;
                    end
                    else
                    begin
                        depth_next = depth_m1;
                        if ({1'b0, idx_reg} < low_reg)
                        begin
                            low_next = {1'b0, idx_reg};
                        end
                        state_next = dsa_pkg::B_MUL;
                    end
                end
                else if (idx_p1 < depth_reg)
                begin
                    re       = 1'b1;
                    raddr    = idx_p1[dsa_pkg::SLOT_W-1:0];
                    idx_next = idx_p1[dsa_pkg::SLOT_W-1:0];
                end
                else
                begin
                    st_next    = dsa_pkg::ST_NOT_FREE;
                    slot_next  = '0;
                    state_next = dsa_pkg::B_DONE;
                end
            end
            dsa_pkg::B_SHIFT:
            begin
                we       = 1'b1;
                waddr    = idx_reg;
                wdata    = rd_val;
                idx_next = idx_p1[dsa_pkg::SLOT_W-1:0];
                if (idx_p2 < depth_reg)
                begin
                    re    = 1'b1;
                    raddr = idx_p2[dsa_pkg::SLOT_W-1:0];
                end
                else
                begin
                    depth_next = depth_m1;
                    if ({1'b0, fidx_reg} < low_reg)
                    begin
                        low_next = {1'b0, fidx_reg};
                    end
                    state_next = dsa_pkg::B_MUL;
                end
            end
            dsa_pkg::B_MUL:
            begin
                mul_next   = dsa_pkg::SPAN_W'(slot_reg) * dsa_pkg::SPAN_W'(cfg.size);
                state_next = dsa_pkg::B_ADD;
            end
            dsa_pkg::B_ADD:
            begin
                hnd_next   = cfg.base + dsa_pkg::HANDLE_W'(mul_reg);
                state_next = dsa_pkg::B_DONE;
            end
            dsa_pkg::B_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = dsa_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = dsa_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dsa_pkg::B_IDLE;
            depth_reg     <= dsa_pkg::COUNT_RESET;
            low_reg       <= dsa_pkg::COUNT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (refill.req)
            begin
                depth_reg <= refill.count;
                low_reg   <= refill.count;
            end
            else
            begin
                depth_reg <= depth_next;
                low_reg   <= low_next;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        fidx_reg <= fidx_next;
        slot_reg <= slot_next;
        mul_reg  <= mul_next;
        hnd_reg  <= hnd_next;
        st_reg   <= st_next;
        if (re)
        begin
            virt_reg <= ({1'b0, raddr} < low_reg);
            vval_reg <= vval_full[dsa_pkg::SLOT_W-1:0];
        end
        if (load_out)
        begin
            out_handle_reg <= hnd_reg;
            out_slot_reg   <= slot_reg;
            out_status_reg <= st_reg;
            out_count_reg  <= depth_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign handle_out = out_handle_reg;
    assign slot_out   = out_slot_reg;
    assign status     = out_status_reg;
    assign free_count = out_count_reg;

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= cfg.count)
        else $error("stack depth above slot count");

    a_low_bound: assert property (@(posedge clk) disable iff (!rst_n)
        low_reg <= cfg.count)
        else $error("fill mark above slot count");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dsa_pkg::B_DONE && st_reg == dsa_pkg::ST_EMPTY) |-> (depth_reg == '0))
        else $error("empty status with nonempty stack");

endmodule

[rtl/descriptor_slot_allocator.sv]
// Descriptor slot allocator top: config registers, front end, queue, stack engine.
// Steps: pop reads the stack top and forms its handle by a multiply-add; push runs a range
// check and a 10-step slot division; reserve finds the slot and moves later entries down.
// One item is worked at a time per part; the stack RAM's single read port sets reserve time.
// Reset: async, active low; no clearing pass, unwritten stack entries below a fill mark
// read as their refill values, so items are taken from the first cycle after reset.
module descriptor_slot_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     cmd,
    input  logic [dsa_pkg::HANDLE_W-1:0]   handle_in,
    input  logic [dsa_pkg::SLOT_W-1:0]     slot_in,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [dsa_pkg::HANDLE_W-1:0]   handle_out,
    output logic [dsa_pkg::SLOT_W-1:0]     slot_out,
    output logic [1:0]                     status,
    output logic [dsa_pkg::CNT_W-1:0]      free_count,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dsa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dsa_pkg::HANDLE_W-1:0]   cfg_wdata
);

    logic [dsa_pkg::HANDLE_W-1:0]  base_reg;
    logic [dsa_pkg::SIZE_W-1:0]    size_reg;
    logic [dsa_pkg::CNT_W-1:0]     count_reg;
    logic                          cfg_wr;
    dsa_pkg::cfg_t                 cfg;
    dsa_pkg::refill_t              refill;
    logic                          q_push, q_full, q_pop, q_empty;
    dsa_pkg::entry_t               q_entry, q_head;

    assign cfg_ready    = 1'b1;
    assign cfg_wr       = cfg_valid && cfg_ready;
    assign cfg.base     = base_reg;
    assign cfg.size     = dsa_pkg::eff_size(size_reg);
    assign cfg.count    = dsa_pkg::eff_count(count_reg);
    assign refill.req   = cfg_wr && (cfg_index == dsa_pkg::REG_COUNT);
    assign refill.count = dsa_pkg::eff_count(cfg_wdata[dsa_pkg::CNT_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= dsa_pkg::BASE_RESET;
            size_reg  <= dsa_pkg::SIZE_RESET;
            count_reg <= dsa_pkg::COUNT_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                dsa_pkg::REG_BASE:  base_reg  <= cfg_wdata;
                dsa_pkg::REG_SIZE:  size_reg  <= cfg_wdata[dsa_pkg::SIZE_W-1:0];
                dsa_pkg::REG_COUNT: count_reg <= cfg_wdata[dsa_pkg::CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    dsa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (dsa_pkg::cmd_t'(cmd)),
        .handle_in (handle_in),
        .slot_in   (slot_in),
        .cfg       (cfg),
        .q_push    (q_push),
        .q_entry   (q_entry),
        .q_full    (q_full)
    );

    dsa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty)
    );

    dsa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .refill     (refill),
        .q_head     (q_head),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .handle_out (handle_out),
        .slot_out   (slot_out),
        .status     (status),
        .free_count (free_count)
    );

endmodule
